### rtl/ppmfd_pkg.sv
// ---------------------------------------------------------------------------
// ppmfd_pkg
// Shared types and constants of the PPM frame decoder.
// ---------------------------------------------------------------------------
package ppmfd_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 16;

   // channel position: minus one (all ones) or 0..31
   localparam int              POS_WIDTH = 6;
   localparam logic [POS_WIDTH-1:0] POS_NONE = 6'h3F;
   localparam logic [POS_WIDTH-1:0] POS_TOP  = 6'd31;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SYNC_THRESHOLD = 3'd0,
      CSR_MAX_CHANNELS   = 3'd1,
      CSR_RANGE_CHECK    = 3'd2,
      CSR_RANGE_MIN      = 3'd3,
      CSR_RANGE_MAX      = 3'd4
   } csr_index_type;

   localparam logic [15:0] SYNC_THRESHOLD_RESET = 16'd3000;
   localparam logic [4:0]  MAX_CHANNELS_RESET   = 5'd8;
   localparam logic        RANGE_CHECK_RESET    = 1'b0;
   localparam logic [15:0] RANGE_MIN_RESET      = 16'd0;
   localparam logic [15:0] RANGE_MAX_RESET      = 16'hFFFF;

   typedef enum logic [2:0] {
      PHASE_WAIT  = 3'b001,
      PHASE_LEARN = 3'b010,
      PHASE_RUN   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [31:0] edge_time;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] pulse_width;
      logic [3:0]  channel_index;
      logic        accepted;
      logic        frame_complete;
      logic [4:0]  channels_seen;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] sync_threshold;
      logic [4:0]  max_channels;
      logic        range_check;
      logic [15:0] range_min;
      logic [15:0] range_max;
   } cfg_type;

   typedef struct packed {
      logic [31:0]          last_edge_time;
      logic                 have_edge;
      phase_type            phase;
      logic [POS_WIDTH-1:0] position;
      logic [4:0]           learned;
   } track_type;

endpackage

### rtl/ppmfd_stream_if.sv
// ---------------------------------------------------------------------------
// ppmfd_stream_if
// Valid/ready channel carrying one payload per beat.
// ---------------------------------------------------------------------------
interface ppmfd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/ppmfd_step.sv
// ---------------------------------------------------------------------------
// ppmfd_step
// Per-edge decode: interval, sync detect, phase machine, channel result.
// ---------------------------------------------------------------------------
module ppmfd_step import ppmfd_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
   input  cfg_type         cfg,
   input  track_type       track,
   input  logic [31:0]     edge_time,
   output track_type       track_next,
   output rsp_payload_type rsp
);

   localparam logic [POS_WIDTH-1:0] ParamLimit = POS_WIDTH'(MAX_CHANNELS);

   logic [15:0]          diff;
   logic                 is_sync;
   logic [POS_WIDTH-1:0] limit;
   logic [POS_WIDTH-1:0] pos_adv;
   logic [POS_WIDTH-1:0] pos_inc;
   logic                 in_limit;
   logic                 in_range;

   always_comb begin
      diff    = track.have_edge ? 16'(edge_time - track.last_edge_time) : 16'd0;
      is_sync = (diff >= cfg.sync_threshold);

      limit = (POS_WIDTH'(cfg.max_channels) > ParamLimit) ? ParamLimit
                                                           : POS_WIDTH'(cfg.max_channels);

      // saturating advance from minus one
      if (track.position == POS_NONE) begin
         pos_adv = '0;
      end else if (track.position < POS_TOP) begin
         pos_adv = track.position + POS_WIDTH'(1);
      end else begin
         pos_adv = POS_TOP;
      end
      pos_inc  = pos_adv + POS_WIDTH'(1);
      in_limit = (pos_adv <= POS_TOP) && (pos_adv < limit);
      in_range = !cfg.range_check || ((diff >= cfg.range_min) && (diff <= cfg.range_max));
   end

   always_comb begin
      track_next                = track;
      track_next.last_edge_time = edge_time;
      track_next.have_edge      = 1'b1;
      rsp                       = '0;

      unique case (track.phase)
         PHASE_WAIT: begin
            if (is_sync) track_next.phase = PHASE_LEARN;
         end
         PHASE_LEARN: begin
            if (!is_sync) begin
               track_next.position = pos_adv;
               if (in_limit && (pos_inc > POS_WIDTH'(track.learned))) begin
                  track_next.learned = 5'(pos_inc);
               end
            end else begin
               track_next.position = POS_NONE;
               track_next.phase    = PHASE_RUN;
            end
         end
         PHASE_RUN: begin
            if (!is_sync) begin
               track_next.position = pos_adv;
               if (in_limit && in_range) begin
                  rsp.accepted       = 1'b1;
                  rsp.pulse_width    = diff;
                  rsp.channel_index  = 4'(pos_adv);
                  rsp.frame_complete = (diff != 16'd0) &&
                                       (pos_inc >= POS_WIDTH'(track.learned));
               end
            end else begin
               track_next.position = POS_NONE;
            end
         end
         default: begin
         end
      endcase

      rsp.channels_seen = track_next.learned;
   end

endmodule

### rtl/ppm_frame_decoder.sv
// ---------------------------------------------------------------------------
// ppm_frame_decoder
// PPM radio-control frame decoder: one edge timestamp in, one channel report out.
// ---------------------------------------------------------------------------
//
//  channel    dir  handshake            beat contents
//  req_chan   in   valid/ready          edge_time
//  rsp_chan   out  valid/ready          pulse_width, channel_index, accepted,
//                                       frame_complete, channels_seen
//  csr_*      in   write enable only    csr_index, csr_write_data (no read-back)
//
//  Cycles: one beat per clock sustained while rsp_chan is ready; the input register
//  loads on the request beat and the result register loads from it once free, so a
//  result beat leaves through both registers. The decode sits in one combinational step
//  between them, and the tracking state updates as the result register loads,
//  so the next edge sees it in the following cycle.
//  Reset: synchronous, active high; clears tracking state, config to defaults.
//  Stalls: a held result blocks the input register only; req_chan stays ready
//  while the input register is empty or moving on.
//
module ppm_frame_decoder import ppmfd_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   ppmfd_stream_if.sink               req_chan,
   ppmfd_stream_if.source             rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // ---- configuration registers ----
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SYNC_THRESHOLD: cfg_in.sync_threshold = csr_write_data;
            CSR_MAX_CHANNELS:   cfg_in.max_channels   = csr_write_data[4:0];
            CSR_RANGE_CHECK:    cfg_in.range_check    = csr_write_data[0];
            CSR_RANGE_MIN:      cfg_in.range_min      = csr_write_data;
            CSR_RANGE_MAX:      cfg_in.range_max      = csr_write_data;
            default: ;  // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_threshold <= SYNC_THRESHOLD_RESET;
         cfg_ff.max_channels   <= MAX_CHANNELS_RESET;
         cfg_ff.range_check    <= RANGE_CHECK_RESET;
         cfg_ff.range_min      <= RANGE_MIN_RESET;
         cfg_ff.range_max      <= RANGE_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- handshake control ----
   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_time_ff, in_time_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic        rsp_open;
   logic        step_fire;
   logic        req_beat;

   assign rsp_open  = !rsp_valid_ff || rsp_chan.ready;
   assign step_fire = in_valid_ff && rsp_open;
   assign req_chan.ready = !in_valid_ff || step_fire;
   assign req_beat  = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_beat || (in_valid_ff && !step_fire);
   assign in_time_in   = req_beat ? req_chan.data.edge_time : in_time_ff;
   assign rsp_valid_in = step_fire || (rsp_valid_ff && !rsp_chan.ready);

   // ---- decode step ----
   track_type       track_ff, track_in, track_next;
   rsp_payload_type step_rsp;

   ppmfd_step #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_step (
      .cfg        (cfg_ff),
      .track      (track_ff),
      .edge_time  (in_time_ff),
      .track_next (track_next),
      .rsp        (step_rsp)
   );

   // state only moves when the edge's result is loaded
   assign track_in    = step_fire ? track_next : track_ff;
   assign rsp_data_in = step_fire ? step_rsp : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         track_ff.last_edge_time <= '0;
         track_ff.have_edge      <= 1'b0;
         track_ff.phase          <= PHASE_WAIT;
         track_ff.position       <= POS_NONE;
         track_ff.learned        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         track_ff     <= track_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      in_time_ff  <= in_time_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // ---- assertions ----
   a_learned_monotonic: assert property (@(posedge clock)
      !$past(reset) && !reset |-> track_ff.learned >= $past(track_ff.learned))
      else $error("learned channel count decreased");

   a_position_legal: assert property (@(posedge clock) disable iff (reset)
      (track_ff.position == POS_NONE) || (track_ff.position <= POS_TOP))
      else $error("channel position out of range");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> $stable(track_ff))
      else $error("tracking state moved without a decode step");

   a_complete_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_complete |->
         rsp_data_ff.accepted && (rsp_data_ff.pulse_width != 16'd0))
      else $error("frame complete without an accepted nonzero width");

endmodule
